// File: rtl/toe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP option extractor package
// Shared widths, option kind codes and configuration register indexes.
// ----------------------------------------------------------------------------
package toe_pkg;

  // Payload widths.
  localparam int unsigned TOE_BYTE_W   = 8;
  localparam int unsigned TOE_DATA_W   = 64;
  localparam int unsigned TOE_KIND_W   = 8;
  localparam int unsigned TOE_LEN_W    = 6;
  localparam int unsigned TOE_CFG_W    = 8;
  localparam int unsigned TOE_CFG_IDX_W = 1;

  // Default size of the options area in bytes.
  localparam int unsigned TOE_MAX_OPT_BYTES = 40;

  // Option kinds with a fixed meaning.
  localparam logic [TOE_BYTE_W-1:0] TOE_KIND_EOL = 8'd0;
  localparam logic [TOE_BYTE_W-1:0] TOE_KIND_NOP = 8'd1;

  // Smallest legal length byte (kind plus length).
  localparam logic [TOE_BYTE_W-1:0] TOE_MIN_LEN = 8'd2;

  // Configuration register indexes.
  localparam logic [TOE_CFG_IDX_W-1:0] TOE_REG_WANTED_KIND   = 1'd0;
  localparam logic [TOE_CFG_IDX_W-1:0] TOE_REG_WANTED_LENGTH = 1'd1;

  // Register reset values.
  localparam logic [TOE_KIND_W-1:0] TOE_RST_WANTED_KIND   = 8'd254;
  localparam logic [TOE_LEN_W-1:0]  TOE_RST_WANTED_LENGTH = 6'd8;

endpackage

// File: rtl/toe_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP option extractor channels
// Valid/ready channels for option bytes in and scan results out.
// ----------------------------------------------------------------------------
interface toe_byte_if;
  logic                        valid;
  logic                        ready;
  logic [toe_pkg::TOE_BYTE_W-1:0] option_byte;
  logic                        last_byte;

  modport source (output valid, output option_byte, output last_byte, input ready);
  modport sink   (input valid, input option_byte, input last_byte, output ready);
endinterface

interface toe_result_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [toe_pkg::TOE_DATA_W-1:0] option_data;

  modport source (output valid, output found, output option_data, input ready);
  modport sink   (input valid, input found, input option_data, output ready);
endinterface

// File: rtl/tcp_option_extractor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP option extractor
// Walks a TCP options area one byte per beat and reports whether an option
// with the configured kind and length is present, with its first 8 bytes.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                       Beat taken when
//  byte_i    in   option_byte[7:0], last_byte   valid && ready
//  result_o  out  found, option_data[63:0]      valid && ready
//  cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i  cfg_we_i high
//
//  One byte is accepted per cycle while byte_i.ready is high; the parser state updates in that cycle.
//  The result of an area is registered at the edge that takes its last byte
//  and is offered from the next cycle on.
//  The result register is the only stall point: byte_i.ready drops only
//  while a result is held and result_o.ready is low.
//  Reset clears the parser to the start of an area and loads default config.
// ----------------------------------------------------------------------------
module tcp_option_extractor_unit #(
  parameter int unsigned MAX_OPTION_BYTES = toe_pkg::TOE_MAX_OPT_BYTES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [toe_pkg::TOE_CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [toe_pkg::TOE_CFG_W-1:0]     cfg_data_i,
  toe_byte_if.sink                          byte_i,
  toe_result_if.source                      result_o
);
  import toe_pkg::*;

  localparam int unsigned LeftW = $clog2(MAX_OPTION_BYTES + 1);
  localparam int unsigned CmpW  = TOE_BYTE_W + 1;
  localparam int unsigned Lanes = TOE_DATA_W / TOE_BYTE_W;
  localparam int unsigned IdxW  = $clog2(Lanes);
  localparam logic [LeftW-1:0] AreaBytes = LeftW'(MAX_OPTION_BYTES);

  typedef enum logic [1:0] {
    PH_KIND,
    PH_LEN,
    PH_BODY
  } phase_e;

  // Configuration registers.
  logic [TOE_KIND_W-1:0] wanted_kind_q;
  logic [TOE_LEN_W-1:0]  wanted_len_q;

  // Parser state.
  phase_e                phase_q, phase_d;
  logic [LeftW-1:0]      left_q, left_d;
  logic [TOE_LEN_W-1:0]  skip_q, skip_d;
  logic [TOE_DATA_W-1:0] word_q, word_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic                  done_q, done_d;
  logic                  match_q, match_d;
  logic                  capt_q, capt_d;

  // Result register.
  logic                  out_valid_q, out_valid_d;
  logic                  out_found_q;
  logic [TOE_DATA_W-1:0] out_data_q;

  logic                  in_acc;
  logic [TOE_BYTE_W-1:0] b;
  logic                  put_en;
  logic [CmpW-1:0]       len_limit;

  assign byte_i.ready = !out_valid_q || result_o.ready;
  assign in_acc       = byte_i.valid && byte_i.ready;
  assign b            = byte_i.option_byte;
  assign len_limit    = CmpW'(left_q) + CmpW'(1);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_kind_q <= TOE_RST_WANTED_KIND;
      wanted_len_q  <= TOE_RST_WANTED_LENGTH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        TOE_REG_WANTED_KIND:   wanted_kind_q <= cfg_data_i[TOE_KIND_W-1:0];
        TOE_REG_WANTED_LENGTH: wanted_len_q  <= cfg_data_i[TOE_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // One parser step per accepted byte.
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    skip_d  = skip_q;
    word_d  = word_q;
    idx_d   = idx_q;
    done_d  = done_q;
    match_d = match_q;
    capt_d  = capt_q;
    put_en  = 1'b0;

    if (!done_q) begin
      if (left_q == '0) begin
        done_d = 1'b1;
      end else begin
        left_d = left_q - LeftW'(1);
        case (phase_q)
          PH_KIND: begin
            if (b == TOE_KIND_EOL) begin
              done_d = 1'b1;
            end else if (b != TOE_KIND_NOP) begin
              word_d  = TOE_DATA_W'(b);
              idx_d   = IdxW'(1);
              capt_d  = 1'b0;
              phase_d = PH_LEN;
            end
          end
          PH_LEN: begin
            if (b < TOE_MIN_LEN || CmpW'(b) > len_limit) begin
              done_d = 1'b1;
            end else begin
              capt_d  = (word_q[TOE_KIND_W-1:0] == wanted_kind_q) &&
                        (b == TOE_BYTE_W'(wanted_len_q));
              put_en  = 1'b1;
              skip_d  = b[TOE_LEN_W-1:0] - TOE_LEN_W'(2);
              phase_d = PH_BODY;
              // A two-byte option ends on its length byte.
              if (skip_d == '0) begin
                if (capt_d) begin
                  match_d = 1'b1;
                  done_d  = 1'b1;
                end else begin
                  phase_d = PH_KIND;
                end
              end
            end
          end
          PH_BODY: begin
            put_en = capt_q;
            if (skip_q != '0) begin
              skip_d = skip_q - TOE_LEN_W'(1);
            end
            if (skip_d == '0) begin
              if (capt_q) begin
                match_d = 1'b1;
                done_d  = 1'b1;
              end else begin
                phase_d = PH_KIND;
              end
            end
          end
          default: begin
            phase_d = PH_KIND;
          end
        endcase
      end
    end

    // Capture into the next byte lane; slot zero means the word is full.
    if (put_en && idx_q != '0) begin
      for (int unsigned k = 0; k < Lanes; k++) begin
        if (idx_q == IdxW'(k)) begin
          word_d[k*TOE_BYTE_W +: TOE_BYTE_W] = word_q[k*TOE_BYTE_W +: TOE_BYTE_W] | b;
        end
      end
      idx_d = idx_q + IdxW'(1);
    end
  end

  // Result handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc && byte_i.last_byte) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Parser state and result valid; the last beat rewinds to the area start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_KIND;
      left_q      <= AreaBytes;
      skip_q      <= '0;
      word_q      <= '0;
      idx_q       <= '0;
      done_q      <= 1'b0;
      match_q     <= 1'b0;
      capt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        if (byte_i.last_byte) begin
          phase_q <= PH_KIND;
          left_q  <= AreaBytes;
          skip_q  <= '0;
          word_q  <= '0;
          idx_q   <= '0;
          done_q  <= 1'b0;
          match_q <= 1'b0;
          capt_q  <= 1'b0;
        end else begin
          phase_q <= phase_d;
          left_q  <= left_d;
          skip_q  <= skip_d;
          word_q  <= word_d;
          idx_q   <= idx_d;
          done_q  <= done_d;
          match_q <= match_d;
          capt_q  <= capt_d;
        end
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_acc && byte_i.last_byte) begin
      out_found_q <= match_d;
      out_data_q  <= match_d ? word_d : '0;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.found       = out_found_q;
  assign result_o.option_data = out_data_q;

`ifndef NO_ASSERTIONS
  // A result with no find carries an all-zero data word.
  a_nofind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> (out_data_q == '0))
    else $error("result without find carries nonzero data");

  // A fresh result only follows an accepted last byte.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q && !result_o.ready)) |->
      $past(in_acc && byte_i.last_byte))
    else $error("result appeared without a last byte");

  // The remaining-byte count never exceeds the area size.
  a_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= AreaBytes)
    else $error("byte budget out of range");

  // A find always ends the scan.
  a_match_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_q |-> done_q)
    else $error("match recorded while scan still running");
`endif

endmodule
